FILE: rtl/imu_frame_parser_macros.svh
// assertion macros for the imu frame parser
`ifndef IMU_FRAME_PARSER_MACROS_SVH
`define IMU_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define IFP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define IFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/imu_fp_pkg.sv
package imu_fp_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int VALUE_W   = 24;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // frame layout: bytes 0..9 carry header, type and four words
    localparam int FRAME_LEN_DEF = 11;
    localparam int SNAP_N        = 10;

    // queue between front and back
    localparam int Q_DEPTH = 2;

    // register reset values
    localparam logic [BYTE_W-1:0] HDR_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] ACC_RESET = 8'h51;
    localparam logic [BYTE_W-1:0] ANG_RESET = 8'h53;
    localparam logic [BYTE_W-1:0] QUA_RESET = 8'h59;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_HEADER = 2'd0;
    localparam cfg_idx_t REG_ACCEL  = 2'd1;
    localparam cfg_idx_t REG_ANGLE  = 2'd2;
    localparam cfg_idx_t REG_QUAT   = 2'd3;

    // result kinds
    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_ACCEL = 2'd0;
    localparam kind_t KIND_ANGLE = 2'd1;
    localparam kind_t KIND_QUAT  = 2'd2;

    // one classified frame, raw words
    typedef struct packed {
        kind_t                     kind;
        logic signed [WORD_W-1:0]  word_a;
        logic signed [WORD_W-1:0]  word_b;
        logic signed [WORD_W-1:0]  word_c;
        logic signed [WORD_W-1:0]  word_d;
    } frame_t;

endpackage

FILE: rtl/imu_fp_front.sv
module imu_fp_front #(
    parameter int FRAME_LEN = imu_fp_pkg::FRAME_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [imu_fp_pkg::BYTE_W-1:0] in_byte,
    input  logic                          cfg_valid,
    input  imu_fp_pkg::cfg_idx_t          cfg_index,
    input  logic [imu_fp_pkg::BYTE_W-1:0] cfg_data,
    output logic                          push_valid,
    input  logic                          push_ready,
    output imu_fp_pkg::frame_t            push_frame
);
    import imu_fp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN);

    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] accel_reg;
    logic [BYTE_W-1:0] angle_reg;
    logic [BYTE_W-1:0] quat_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [BYTE_W-1:0] store_reg [SNAP_N];
    logic [BYTE_W-1:0] snap [SNAP_N];

    logic accept;
    logic hdr_ok;
    logic last;
    logic is_acc;
    logic is_ang;
    logic is_qua;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HDR_RESET;
            accel_reg  <= ACC_RESET;
            angle_reg  <= ANG_RESET;
            quat_reg   <= QUA_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADER: header_reg <= cfg_data;
                REG_ACCEL:  accel_reg  <= cfg_data;
                REG_ANGLE:  angle_reg  <= cfg_data;
                REG_QUAT:   quat_reg   <= cfg_data;
            endcase
        end
    end

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // frame as seen with the incoming byte in its slot
    always_comb begin
        for (int i = 0; i < SNAP_N; i++) begin
            snap[i] = (count_reg == CNT_W'(i)) ? in_byte : store_reg[i];
        end
    end

    assign hdr_ok = (snap[0] == header_reg);
    assign last   = (count_reg == CNT_W'(FRAME_LEN - 1));

    // type match, acceleration first, then angle, then quaternion
    assign is_acc = (snap[1] == accel_reg);
    assign is_ang = !is_acc && (snap[1] == angle_reg);
    assign is_qua = !is_acc && !is_ang && (snap[1] == quat_reg);

    // byte position
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (!hdr_ok || last) begin
                count_next = '0;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // frame store, each slot written when its byte arrives
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SNAP_N; i++) begin
            if (accept && count_reg == CNT_W'(i)) begin
                store_reg[i] <= in_byte;
            end
        end
    end

    // hand a complete known frame to the queue
    assign push_valid = accept && hdr_ok && last && (is_acc || is_ang || is_qua);

    always_comb begin
        if (is_acc) begin
            push_frame.kind = KIND_ACCEL;
        end else if (is_ang) begin
            push_frame.kind = KIND_ANGLE;
        end else begin
            push_frame.kind = KIND_QUAT;
        end
        push_frame.word_a = {snap[3], snap[2]};
        push_frame.word_b = {snap[5], snap[4]};
        push_frame.word_c = {snap[7], snap[6]};
        push_frame.word_d = {snap[9], snap[8]};
    end

endmodule

FILE: rtl/imu_fp_queue.sv
module imu_fp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  imu_fp_pkg::frame_t wr_frame,
    output logic               rd_valid,
    input  logic               rd_ready,
    output imu_fp_pkg::frame_t rd_frame
);
    import imu_fp_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    frame_t           mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CNT_W'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_frame = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // pointers wrap at the queue depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

FILE: rtl/imu_fp_back.sv
module imu_fp_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  frm_valid,
    output logic                                  frm_ready,
    input  imu_fp_pkg::frame_t                    frm,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output imu_fp_pkg::kind_t                     out_kind,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] out_a,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] out_b,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] out_c,
    output logic signed [imu_fp_pkg::WORD_W-1:0]  out_d
);
    import imu_fp_pkg::*;

    localparam logic signed [8:0] ANGLE_SCALE = 9'sd180;

    logic                       valid_reg;
    kind_t                      kind_reg;
    logic signed [VALUE_W-1:0]  a_reg;
    logic signed [VALUE_W-1:0]  b_reg;
    logic signed [VALUE_W-1:0]  c_reg;
    logic signed [WORD_W-1:0]   d_reg;
    logic signed [VALUE_W-1:0]  a_next;
    logic signed [VALUE_W-1:0]  b_next;
    logic signed [VALUE_W-1:0]  c_next;
    logic signed [WORD_W-1:0]   d_next;
    logic                       take;

    // scale one word: shift for acceleration, constant multiply for angle
    function automatic logic signed [VALUE_W-1:0] scale_word(
        input kind_t                    k,
        input logic signed [WORD_W-1:0] w
    );
        logic signed [WORD_W+8:0] prod;
        logic signed [VALUE_W-1:0] res;
        prod = w * ANGLE_SCALE;
        case (k)
            KIND_ACCEL: res = {{(VALUE_W-WORD_W-4){w[WORD_W-1]}}, w, 4'b0000};
            KIND_ANGLE: res = prod[VALUE_W-1:0];
            default:    res = {{(VALUE_W-WORD_W){w[WORD_W-1]}}, w};
        endcase
        return res;
    endfunction

    assign take      = frm_valid && (!valid_reg || out_ready);
    assign frm_ready = !valid_reg || out_ready;

    assign a_next = scale_word(frm.kind, frm.word_a);
    assign b_next = scale_word(frm.kind, frm.word_b);
    assign c_next = scale_word(frm.kind, frm.word_c);
    assign d_next = (frm.kind == KIND_QUAT) ? frm.word_d : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg <= frm.kind;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            d_reg    <= d_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_c     = c_reg;
    assign out_d     = d_reg;

endmodule

FILE: rtl/imu_frame_parser.sv
// Byte-serial parser for fixed-length inertial sensor frames. One received
// byte is taken per item and the block accepts a byte in every clock cycle;
// s_ready drops only when the two-entry frame queue is full, which happens
// only while m_ready holds results back. A frame whose first byte matches
// header_byte and whose type byte matches accel_code, angle_code or
// quat_code (checked in that order) yields one result after its last byte
// is accepted, registered first in the queue, then in the output register
// where the scaling multiply lands. Acceleration words come out times 16,
// angle words times 180, quaternion words unscaled with the fourth word on
// m_value_d (zero otherwise). Frames of other types are dropped, no checksum
// is checked. Configuration writes are taken in any cycle (cfg_ready is
// always high) and must only be made while no frame is in flight.
`include "imu_frame_parser_macros.svh"

module imu_frame_parser #(
    parameter int FRAME_LEN = imu_fp_pkg::FRAME_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [imu_fp_pkg::BYTE_W-1:0]         s_rx_byte,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output imu_fp_pkg::kind_t                     m_kind,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] m_value_a,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] m_value_b,
    output logic signed [imu_fp_pkg::VALUE_W-1:0] m_value_c,
    output logic signed [imu_fp_pkg::WORD_W-1:0]  m_value_d,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  imu_fp_pkg::cfg_idx_t                  cfg_index,
    input  logic [imu_fp_pkg::BYTE_W-1:0]         cfg_data
);
    import imu_fp_pkg::*;

    logic   push_valid;
    logic   push_ready;
    frame_t push_frame;
    logic   pop_valid;
    logic   pop_ready;
    frame_t pop_frame;

    assign cfg_ready = 1'b1;

    // byte collection and frame classification
    imu_fp_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame)
    );

    // frame queue between front and back
    imu_fp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_frame (push_frame),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_frame (pop_frame)
    );

    // scaling and output register
    imu_fp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frm_valid (pop_valid),
        .frm_ready (pop_ready),
        .frm       (pop_frame),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_kind  (m_kind),
        .out_a     (m_value_a),
        .out_b     (m_value_b),
        .out_c     (m_value_c),
        .out_d     (m_value_d)
    );

    // checks
    `IFP_ASSERT_SAME(a_push_room, push_valid, push_ready, "frame pushed into a full queue")
    `IFP_ASSERT_SAME(a_kind_legal, m_valid, (m_kind == KIND_ACCEL || m_kind == KIND_ANGLE || m_kind == KIND_QUAT), "result kind out of range")
    `IFP_ASSERT_SAME(a_d_zero, m_valid && m_kind != KIND_QUAT, m_value_d == '0, "fourth word set on a non-quaternion result")
    `IFP_ASSERT_NEXT(a_queue_drains, pop_valid && pop_ready && !push_valid && !s_valid, m_valid, "queued frame did not reach the output")

endmodule

FILE: verif/tb_top.sv
module tb_top;
    import imu_fp_pkg::*;

    localparam int FRAME_LEN   = FRAME_LEN_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 400000;

    // one expected parser output
    typedef struct {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value_a;
        logic signed [VALUE_W-1:0]  value_b;
        logic signed [VALUE_W-1:0]  value_c;
        logic signed [WORD_W-1:0]   value_d;
    } imu_result_t;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [BYTE_W-1:0]          s_rx_byte = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    kind_t                      m_kind;
    logic signed [VALUE_W-1:0]  m_value_a;
    logic signed [VALUE_W-1:0]  m_value_b;
    logic signed [VALUE_W-1:0]  m_value_c;
    logic signed [WORD_W-1:0]   m_value_d;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    cfg_idx_t                   cfg_index = REG_HEADER;
    logic [BYTE_W-1:0]          cfg_data  = '0;

    // parser shadow state
    logic [BYTE_W-1:0]  hdr_reg;
    logic [BYTE_W-1:0]  acc_reg;
    logic [BYTE_W-1:0]  ang_reg;
    logic [BYTE_W-1:0]  qua_reg;
    logic [BYTE_W-1:0]  frame_buf [FRAME_LEN];
    int                 fill_cnt;
    imu_result_t        pending_results [$];

    // run bookkeeping
    int  fail_cnt    = 0;
    int  cycle_cnt   = 0;
    int  bytes_sent  = 0;
    int  bytes_taken = 0;
    int  reg_writes  = 0;
    int  kind_seen [3];
    bit  fast_mode   = 1'b0;
    int  sink_hold   = 0;

    imu_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_value_a (m_value_a),
        .m_value_b (m_value_b),
        .m_value_c (m_value_c),
        .m_value_d (m_value_d),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // signed little-endian word k of the buffered frame
    function automatic int frame_word(input int k);
        return int'($signed({frame_buf[3 + 2 * k], frame_buf[2 + 2 * k]}));
    endfunction

    // append one byte to the shadow frame, queue a result when a known frame completes
    function automatic void parse_byte(input logic [BYTE_W-1:0] b);
        imu_result_t r;
        int          scale;
        if (fill_cnt >= FRAME_LEN)
            fill_cnt = 0;
        frame_buf[fill_cnt] = b;
        fill_cnt++;
        if (frame_buf[0] != hdr_reg) begin
            fill_cnt = 0;
            return;
        end
        if (fill_cnt < FRAME_LEN)
            return;
        fill_cnt = 0;
        // acceleration wins over angle, angle over quaternion
        if (frame_buf[1] == acc_reg) begin
            r.kind = KIND_ACCEL;
            scale  = 16;
        end else if (frame_buf[1] == ang_reg) begin
            r.kind = KIND_ANGLE;
            scale  = 180;
        end else if (frame_buf[1] == qua_reg) begin
            r.kind = KIND_QUAT;
            scale  = 1;
        end else begin
            return;
        end
        r.value_a = VALUE_W'(frame_word(0) * scale);
        r.value_b = VALUE_W'(frame_word(1) * scale);
        r.value_c = VALUE_W'(frame_word(2) * scale);
        r.value_d = (r.kind == KIND_QUAT) ? WORD_W'(frame_word(3)) : '0;
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want_v,
                                        input logic signed [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_cnt++;
        end
    endfunction

    // shadow update and result compare, sampled at each rising edge
    always @(posedge aclk) begin : scoreboard
        imu_result_t want;
        if (!aresetn) begin
            hdr_reg  = HDR_RESET;
            acc_reg  = ACC_RESET;
            ang_reg  = ANG_RESET;
            qua_reg  = QUA_RESET;
            fill_cnt = 0;
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: kind %0d a %0d b %0d c %0d d %0d",
                           m_kind, m_value_a, m_value_b, m_value_c, m_value_d);
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", {30'd0, want.kind}, {30'd0, m_kind});
                    check_field("value_a", want.value_a, m_value_a);
                    check_field("value_b", want.value_b, m_value_b);
                    check_field("value_c", want.value_c, m_value_c);
                    check_field("value_d", want.value_d, m_value_d);
                    if (want.kind <= KIND_QUAT)
                        kind_seen[want.kind]++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HEADER: hdr_reg = cfg_data;
                    REG_ACCEL:  acc_reg = cfg_data;
                    REG_ANGLE:  ang_reg = cfg_data;
                    REG_QUAT:   qua_reg = cfg_data;
                    default:    ;
                endcase
            end
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                bytes_taken++;
            end
        end
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // result side: random stalls per item, or a long counted hold when asked
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else begin
                stall = fast_mode ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid && sink_hold == 0)
                @(posedge aclk);
        end
    end

    // offer one byte; valid stays high on return so a following item can reuse it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] typ,
                              input logic [WORD_W-1:0] w0, input logic [WORD_W-1:0] w1,
                              input logic [WORD_W-1:0] w2, input logic [WORD_W-1:0] w3);
        send_byte(hdr);
        send_byte(typ);
        send_byte(w0[7:0]);
        send_byte(w0[15:8]);
        send_byte(w1[7:0]);
        send_byte(w1[15:8]);
        send_byte(w2[7:0]);
        send_byte(w2[15:8]);
        send_byte(w3[7:0]);
        send_byte(w3[15:8]);
        // checksum and any trailing bytes are not checked by the block
        for (int i = 10; i < FRAME_LEN; i++)
            send_byte(BYTE_W'($urandom));
    endtask

    // stop offering, let every expected result out, then allow for in-flight frames
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [BYTE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_codes(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] acc,
                             input logic [BYTE_W-1:0] ang, input logic [BYTE_W-1:0] qua);
        set_reg(REG_HEADER, hdr);
        set_reg(REG_ACCEL, acc);
        set_reg(REG_ANGLE, ang);
        set_reg(REG_QUAT, qua);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // reset codes: every kind with extreme words, noise, unknown type
    task automatic test_reset_codes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(HDR_RESET, ACC_RESET, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1234);
        send_frame(HDR_RESET, ANG_RESET, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
        send_frame(HDR_RESET, QUA_RESET, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
        send_frame(HDR_RESET, 8'h52, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
        send_frame(HDR_RESET, ACC_RESET, 16'h0001, 16'hFFFF, 16'h8001, 16'h7FFE);
    endtask

    // several codes equal: accel has priority, then angle, then quaternion
    task automatic test_equal_codes();
        wait_idle();
        set_codes(8'h00, 8'hFF, 8'hFF, 8'hFF);
        send_frame(8'h00, 8'hFF, 16'h7FFF, 16'h8000, 16'h00FF, 16'h5A5A);
        wait_idle();
        set_reg(REG_ACCEL, 8'h00);
        send_frame(8'h00, 8'hFF, 16'h7FFF, 16'h8000, 16'hFF00, 16'h5A5A);
        wait_idle();
        set_reg(REG_ANGLE, 8'h01);
        send_frame(8'h00, 8'hFF, 16'h7FFF, 16'h8000, 16'hFF00, 16'hA5A5);
    endtask

    // header register changed while a partial frame is held
    task automatic test_header_change();
        wait_idle();
        set_codes(HDR_RESET, ACC_RESET, ANG_RESET, QUA_RESET);
        send_byte(HDR_RESET);
        send_byte(ANG_RESET);
        send_byte(8'h34);
        send_byte(8'h12);
        wait_idle();
        set_reg(REG_HEADER, 8'hA5);
        send_byte(8'hA5);
        send_frame(8'hA5, ACC_RESET, 16'h4321, 16'hBCDE, 16'h0F0F, 16'h0000);
        send_frame(8'hA5, QUA_RESET, 16'h0101, 16'hFEFE, 16'h8000, 16'h7FFF);
    endtask

    // receiver holds off long while frames arrive back to back
    task automatic test_backpressure();
        wait_idle();
        set_codes(HDR_RESET, ACC_RESET, ANG_RESET, QUA_RESET);
        fast_mode = 1'b1;
        sink_hold = 300;
        repeat (8)
            send_frame(HDR_RESET, ($urandom_range(0, 1) == 0) ? ACC_RESET : QUA_RESET,
                       pick_word(), pick_word(), pick_word(), pick_word());
        fast_mode = 1'b0;
    endtask

    // phases of register settings, mostly well-formed frames with random content
    task automatic test_random_traffic();
        int                phase;
        int                pick;
        int                n;
        logic [BYTE_W-1:0] typ;
        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            wait_idle();
            case (phase)
                0:       set_codes(HDR_RESET, ACC_RESET, ANG_RESET, QUA_RESET);
                1:       set_codes(8'hFF, 8'h00, 8'h7F, 8'h80);
                2:       set_codes(8'h00, 8'hFF, 8'hFE, 8'h01);
                default: set_codes(BYTE_W'($urandom), BYTE_W'($urandom),
                                   BYTE_W'($urandom), BYTE_W'($urandom));
            endcase
            repeat (25) begin
                if ($urandom_range(0, 7) == 0)
                    fast_mode = !fast_mode;
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    case ($urandom_range(0, 2))
                        0:       typ = acc_reg;
                        1:       typ = ang_reg;
                        default: typ = qua_reg;
                    endcase
                    send_frame(hdr_reg, typ, pick_word(), pick_word(), pick_word(),
                               pick_word());
                end else if (pick < 88) begin
                    send_frame(hdr_reg, BYTE_W'($urandom), pick_word(), pick_word(),
                               pick_word(), pick_word());
                end else if (pick < 94) begin
                    // line noise
                    n = $urandom_range(1, 5);
                    repeat (n) send_byte(BYTE_W'($urandom));
                end else begin
                    // frame cut short
                    n = $urandom_range(1, FRAME_LEN - 2);
                    send_byte(hdr_reg);
                    repeat (n) send_byte(BYTE_W'($urandom));
                end
            end
            phase++;
        end
        fast_mode = 1'b0;
    endtask

    initial begin : run
        kind_seen = '{0, 0, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_codes();
        test_equal_codes();
        test_header_change();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_cnt++;
        end
        $display("%0d bytes over %0d register writes; results checked: accel %0d angle %0d quat %0d",
                 bytes_taken, reg_writes, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("stimulus had noise, cut and unknown frames, equal codes and a long output hold");
        if (fail_cnt == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
